@@ sv/b64e_pkg.sv @@
// Shared types, constants and the alphabet lookup for the base64 stream encoder.
// Used by every module of the encoder; depends on nothing else.
package b64e_pkg;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;
    localparam int JOB_CHARS = 4;
    localparam int IDX_W = $clog2(JOB_CHARS);

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } out_beat_t;

    typedef enum logic [1:0] {
        PH_0 = 2'd0,
        PH_1 = 2'd1,
        PH_2 = 2'd2
    } phase_t;

    typedef struct packed {
        logic [JOB_CHARS-1:0][7:0] chars;
        logic [IDX_W-1:0]          cnt;
        logic                      last;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] c;
        c = 8'h2F;
        case (v) inside
            [6'd0:6'd25]:  c = 8'(8'h41 + {2'b00, v});
            [6'd26:6'd51]: c = 8'(8'h61 + {2'b00, v} - 8'd26);
            [6'd52:6'd61]: c = 8'(8'h30 + {2'b00, v} - 8'd52);
            6'd62:         c = 8'h2B;
            default:       c = 8'h2F;
        endcase
        return c;
    endfunction

endpackage

@@ sv/b64e_front.sv @@
// Front end: accepts raw bytes, tracks group phase and carry bits, forms char jobs.
// Depends on b64e_pkg.
module b64e_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  b64e_pkg::in_beat_t in_data,
    input  b64e_pkg::q_stat_t  q_stat,
    output logic               push,
    output b64e_pkg::job_t     job
);

    b64e_pkg::phase_t phase_reg;
    b64e_pkg::phase_t phase_next;
    logic [3:0]       carry_reg;
    logic [3:0]       carry_next;
    logic [7:0]       b;
    logic             eom;

    assign b        = in_data.data_byte;
    assign eom      = in_data.end_of_message;
    assign in_ready = !q_stat.full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        phase_next = phase_reg;
        carry_next = carry_reg;
        if (push)
        begin
            case (phase_reg)
                b64e_pkg::PH_1:
                begin
                    phase_next = eom ? b64e_pkg::PH_0 : b64e_pkg::PH_2;
                    carry_next = eom ? 4'd0 : b[3:0];
                end
                b64e_pkg::PH_2:
                begin
                    phase_next = b64e_pkg::PH_0;
                    carry_next = 4'd0;
                end
                default:
                begin
                    phase_next = eom ? b64e_pkg::PH_0 : b64e_pkg::PH_1;
                    carry_next = eom ? 4'd0 : {2'b00, b[1:0]};
                end
            endcase
        end
    end

    always_comb
    begin
        job = '0;
        case (phase_reg)
            b64e_pkg::PH_1:
            begin
                job.chars[0] = b64e_pkg::enc_char({carry_reg[1:0], b[7:4]});
                job.chars[1] = b64e_pkg::enc_char({b[3:0], 2'b00});
                job.chars[2] = b64e_pkg::PAD_CHAR;
                job.cnt      = eom ? b64e_pkg::IDX_W'(2) : b64e_pkg::IDX_W'(0);
                job.last     = eom;
            end
            b64e_pkg::PH_2:
            begin
                job.chars[0] = b64e_pkg::enc_char({carry_reg, b[7:6]});
                job.chars[1] = b64e_pkg::enc_char(b[5:0]);
                job.cnt      = b64e_pkg::IDX_W'(1);
                job.last     = eom;
            end
            default:
            begin
                job.chars[0] = b64e_pkg::enc_char(b[7:2]);
                job.chars[1] = b64e_pkg::enc_char({b[1:0], 4'b0000});
                job.chars[2] = b64e_pkg::PAD_CHAR;
                job.chars[3] = b64e_pkg::PAD_CHAR;
                job.cnt      = eom ? b64e_pkg::IDX_W'(3) : b64e_pkg::IDX_W'(0);
                job.last     = eom;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= b64e_pkg::PH_0;
            carry_reg <= 4'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
        end
    end

endmodule

@@ sv/b64e_queue.sv @@
// Short job queue between the front end and the character sequencer.
// Depends on b64e_pkg.
module b64e_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  b64e_pkg::job_t    wr_job,
    input  logic              pop,
    output b64e_pkg::job_t    rd_job,
    output b64e_pkg::q_stat_t stat
);

    b64e_pkg::job_t                  mem [b64e_pkg::QDEPTH];
    logic [b64e_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [b64e_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [b64e_pkg::QCNT_W-1:0]     count_reg;
    logic [b64e_pkg::QPTR_W-1:0]     wr_ptr_next;
    logic [b64e_pkg::QPTR_W-1:0]     rd_ptr_next;
    logic [b64e_pkg::QCNT_W-1:0]     count_next;

    assign rd_job     = mem[rd_ptr_reg];
    assign stat.full  = (count_reg == b64e_pkg::QCNT_W'(b64e_pkg::QDEPTH));
    assign stat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = push ? b64e_pkg::QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? b64e_pkg::QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = b64e_pkg::QCNT_W'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = b64e_pkg::QCNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ sv/b64e_back.sv @@
// Back end: steps through the characters of each job into the output register.
// Depends on b64e_pkg.
module b64e_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  b64e_pkg::job_t      q_job,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output b64e_pkg::out_beat_t out_data
);

    b64e_pkg::job_t             job_reg;
    logic                       busy_reg;
    logic                       busy_next;
    logic [b64e_pkg::IDX_W-1:0] idx_reg;
    logic [b64e_pkg::IDX_W-1:0] idx_next;
    b64e_pkg::out_beat_t        out_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       load;
    logic                       at_last;

    assign load      = busy_reg && (!out_valid_reg || out_ready);
    assign at_last   = (idx_reg == job_reg.cnt);
    assign pop       = q_valid && (!busy_reg || (load && at_last));
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (load)
        begin
            busy_next = !at_last;
            idx_next  = b64e_pkg::IDX_W'(idx_reg + 1'b1);
        end
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= q_job;
        end
        if (load)
        begin
            out_reg.out_char  <= job_reg.chars[idx_reg];
            out_reg.last_char <= job_reg.last && at_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ sv/base64_stream_encoder.sv @@
// Top level of the base64 stream encoder: front end, job queue, character sequencer.
// Depends on b64e_pkg, b64e_front, b64e_queue and b64e_back.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one raw message byte per
//   beat; end_of_message marks the final byte of a message.
//   Output channel (out_valid/out_ready/out_data) carries one base64 character
//   per beat; last_char marks the final character, padding included.
//   Each byte becomes a job of one to four characters in a two-entry queue.
//   On its way out, the first character of a byte is held in a queue entry,
//   then in the job register of the sequencer, then in the output register.
//   Throughput: one output beat per cycle while the receiver is ready, set by the
//   single output register; bytes are taken one per cycle while the queue has
//   room, so sustained input is three bytes per four output characters.
//   Reset clears the group phase, the carry bits, the queue and the output
//   valid flag; the next byte starts a new message.
//   When the receiver stalls, the output beat holds, the sequencer stops, and
//   in_ready drops once both queue entries are taken.
module base64_stream_encoder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  b64e_pkg::in_beat_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output b64e_pkg::out_beat_t out_data
);

    b64e_pkg::job_t    push_job;
    b64e_pkg::job_t    head_job;
    b64e_pkg::q_stat_t q_stat;
    logic              push;
    logic              pop;

    b64e_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_stat   (q_stat),
        .push     (push),
        .job      (push_job)
    );

    b64e_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (push_job),
        .pop    (pop),
        .rd_job (head_job),
        .stat   (q_stat)
    );

    b64e_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (!q_stat.empty),
        .q_job     (head_job),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("job pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("job popped from an empty queue");

    a_stat_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty at once");

    a_pad_not_first: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !in_data.end_of_message) |-> (push_job.cnt < b64e_pkg::IDX_W'(2)))
        else $error("padded job formed without end of message");

endmodule
